// File: design/sorted_set_store_unit_assert.svh
// Assertion helpers for the sorted set store.
`ifndef SORTED_SET_STORE_UNIT_ASSERT_SVH
`define SORTED_SET_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SSU_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("sorted set store: check failed");

// Next-cycle implication, checked out of reset.
`define SSU_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("sorted set store: check failed");

`endif

// File: design/ssu_pkg.sv
package ssu_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int MODE_W     = 2;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_CLEARED   = 3'd6
    } t_status;

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_out_item;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic cmp;  // latch compare flags against the key
        logic ins;  // commit an insert at the located slot
    } t_cell_ctl;

    // Sign-extend the input value, then keep the low DATA_WIDTH bits.
    function automatic t_data make_key(logic signed [VALUE_W-1:0] value);
        logic signed [63:0] ext;
        ext = 64'(value);
        return t_data'(ext[DATA_WIDTH-1:0]);
    endfunction

endpackage

// File: design/sorted_set_store_unit.sv
// Sorted set store: keeps up to CAPACITY signed values in descending order with no
// duplicates, in a row of compare-and-shift cells. Each item is an insert, a lookup
// or a clear (mode 3 acts as a lookup) and yields one result with a status and the
// count after the operation. Each item passes through S_CMP, which latches the compare flags
// in every cell, then S_UPD, which resolves them and shifts the cells on an insert; a new item
// is taken in the cycle the previous result is written, whatever the fill, unless the result
// register is held by the consumer.
`include "sorted_set_store_unit_assert.svh"

module sorted_set_store_unit
    import ssu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [MODE_W-1:0] r_mode;
    t_data             r_key;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid;
    t_out_item         r_out_item;
    t_status           n_status;

    logic      out_can;
    logic      accept;
    logic      commit;
    logic      dup;
    logic      full;
    logic      do_ins;
    t_cell_ctl cell_ctl;

    t_data               w_value [CAPACITY];
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_eq;

    assign out_can    = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_UPD) && out_can);
    assign accept     = i_in_valid && o_in_ready;
    assign commit     = (r_state == S_UPD) && out_can;

    assign dup    = |w_eq;
    assign full   = (r_count == CNT_W'(CAPACITY));
    assign do_ins = commit && (r_mode == MODE_INSERT) && !dup && !full;

    assign cell_ctl.cmp = (r_state == S_CMP);
    assign cell_ctl.ins = do_ins;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            ssu_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_occ        (r_count > CNT_W'(g)),
                .i_key        (r_key),
                .i_left_value (r_key),
                .i_left_gt    (1'b1),
                .o_value      (w_value[g]),
                .o_gt         (w_gt[g]),
                .o_eq         (w_eq[g])
            );
        end else begin : g_body
            ssu_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_occ        (r_count > CNT_W'(g)),
                .i_key        (r_key),
                .i_left_value (w_value[g-1]),
                .i_left_gt    (w_gt[g-1]),
                .o_value      (w_value[g]),
                .o_gt         (w_gt[g]),
                .o_eq         (w_eq[g])
            );
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_NOT_FOUND;
        case (r_mode)
            MODE_CLEAR: begin
                n_count  = '0;
                n_status = ST_CLEARED;
            end
            MODE_INSERT: begin
                if (dup) begin
                    n_status = ST_DUPLICATE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count  = r_count + 1'b1;
                    n_status = ST_INSERTED;
                end
            end
            default: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (dup) begin
                    n_status = ST_FOUND;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                // Hold while the previous result still waits.
                if (out_can) begin
                    n_state = accept ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_in_item.mode;
            r_key  <= make_key(i_in_item.value);
        end
        if (commit) begin
            r_out_item.status <= n_status;
            r_out_item.count  <= COUNT_W'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `SSU_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SSU_ASSERT_IMP(a_no_take_in_cmp, r_state == S_CMP, !o_in_ready)
    `SSU_ASSERT_IMP(a_result_from_upd, $rose(r_out_valid), $past(r_state == S_UPD))
    `SSU_ASSERT_NEXT(a_insert_grows, do_ins, r_count == $past(r_count) + 1'b1)

endmodule

// File: design/ssu_cell.sv
module ssu_cell
    import ssu_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  t_data     i_key,
    input  t_data     i_left_value,
    input  logic      i_left_gt,
    output t_data     o_value,
    output logic      o_gt,
    output logic      o_eq
);

    t_data r_value;
    logic  r_gt;
    logic  r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_gt <= i_occ && (r_value > i_key);
            r_eq <= i_occ && (r_value == i_key);
        end
        // Larger entries hold; the first smaller slot takes the key, the rest shift down.
        if (i_ctl.ins && !r_gt) begin
            r_value <= i_left_gt ? i_key : i_left_value;
        end
    end

    assign o_value = r_value;
    assign o_gt    = r_gt;
    assign o_eq    = r_eq;

endmodule

// File: verif/tb_sorted_set_store_unit.sv
`timescale 1ns / 1ps

module tb_sorted_set_store_unit
    import ssu_pkg::*;
();

    // mode 3 has no name in the package; the block treats it as a lookup
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int TAIL_CYCLES  = 8;

    // Tracks the sorted contents and queues the status and count each item should return.
    class set_scoreboard;
        t_data       held[CAPACITY];
        int unsigned fill;
        t_out_item   want_q[$];
        int unsigned errors;

        function void note_input(t_in_item it);
            t_data       key;
            int unsigned pos;
            t_out_item   want;
            key = t_data'(it.value);
            pos = 0;
            while (pos < fill && held[pos] > key) pos++;
            case (it.mode)
                MODE_CLEAR: begin
                    // contents stay, only the count drops
                    fill = 0;
                    want.status = ST_CLEARED;
                end
                MODE_INSERT: begin
                    if (pos < fill && held[pos] == key) begin
                        want.status = ST_DUPLICATE;
                    end else if (fill >= CAPACITY) begin
                        want.status = ST_FULL;
                    end else begin
                        for (int i = fill; i > pos; i--) held[i] = held[i-1];
                        held[pos] = key;
                        fill++;
                        want.status = ST_INSERTED;
                    end
                end
                default: begin
                    if (fill == 0) begin
                        want.status = ST_EMPTY;
                    end else if (pos < fill && held[pos] == key) begin
                        want.status = ST_FOUND;
                    end else begin
                        want.status = ST_NOT_FOUND;
                    end
                end
            endcase
            want.count = COUNT_W'(fill);
            want_q.push_back(want);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (want_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, got status %0d count %0d",
                         $time, got.status, got.count);
                return;
            end
            want = want_q.pop_front();
            if (got.status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
            end
            if (got.count !== want.count) begin
                errors++;
                $display("%0t: count expected %0d, got %0d", $time, want.count, got.count);
            end
        endfunction

        function int unsigned pending();
            return want_q.size();
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    set_scoreboard sb;
    int            burst_left;
    int            rx_left;
    int            rx_style;
    int            stall_cycles;
    t_data         recent[$];

    sorted_set_store_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Present one item, with a random gap at the end of each burst, and hold it until taken.
    task automatic push_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 30);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(it);
    endtask

    task automatic run_op(input logic [MODE_W-1:0] mode, input logic signed [VALUE_W-1:0] value);
        t_in_item it;
        it.mode  = mode;
        it.value = value;
        push_item(it);
    endtask

    // Hold the sender until every outstanding item has come back.
    task automatic drain_wait();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 48) - 32'd24;
            4, 5:       v = $urandom;
            6: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0001;
                endcase
            end
            default: begin
                if (recent.size() > 0) v = recent[$urandom_range(0, recent.size() - 1)];
                else v = $urandom;
            end
        endcase
        return v;
    endfunction

    function automatic t_in_item pick_item();
        t_in_item it;
        int       r;
        r = $urandom_range(0, 99);
        it.value = pick_value();
        if (r < 2) begin
            it.mode = MODE_CLEAR;
        end else if (r < 6) begin
            it.mode = MODE_SPARE;
        end else if (r < 55) begin
            it.mode = MODE_INSERT;
            recent.push_back(t_data'(it.value));
            if (recent.size() > 32) void'(recent.pop_front());
        end else begin
            it.mode = MODE_LOOKUP;
        end
        return it;
    endfunction

    // Sink: check every taken item, then stall on a pattern that changes every so often.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
        if (rx_left == 0) begin
            rx_style = $urandom_range(0, 3);
            rx_left  = $urandom_range(1, 60);
        end
        rx_left--;
        case (rx_style)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 3) != 0);
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= rx_left[0];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        burst_left   = 0;
        rx_left      = 0;
        rx_style     = 0;
        stall_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty store, extremes, duplicates, fill to capacity, clear
        run_op(MODE_LOOKUP, 32'sd5);
        run_op(MODE_SPARE,  32'sd0);
        run_op(MODE_INSERT, 32'h7FFF_FFFF);
        run_op(MODE_INSERT, 32'h8000_0000);
        run_op(MODE_INSERT, 32'sd0);
        run_op(MODE_INSERT, -32'sd1);
        run_op(MODE_INSERT, 32'sd0);
        run_op(MODE_LOOKUP, -32'sd1);
        run_op(MODE_LOOKUP, 32'sd5);
        run_op(MODE_SPARE,  32'h8000_0000);
        for (int i = 1; i <= 12; i++) run_op(MODE_INSERT, i * 1000 - 6500);
        run_op(MODE_INSERT, 32'sd12345);
        run_op(MODE_INSERT, 32'h7FFF_FFFF);
        run_op(MODE_CLEAR,  32'hFFFF_FFFF);
        run_op(MODE_LOOKUP, 32'sd0);
        drain_wait();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) drain_wait();
            push_item(pick_item());
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
